FILE: hw/rtl/cde_pkg.sv
package cde_pkg;

    localparam int CDE_DEPTH  = 64;
    localparam int CDE_DATA_W = 32;
    localparam int FUNC_W     = 3;
    localparam int POS_W      = 6;
    localparam int CNT_W      = 7;

    localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_ROTATE     = 3'd4;
    localparam logic [FUNC_W-1:0] FN_READ       = 3'd5;
    localparam logic [FUNC_W-1:0] FN_FIND       = 3'd6;

    typedef struct packed {
        logic [FUNC_W-1:0]            func;
        logic signed [CDE_DATA_W-1:0] data_in;
        logic [POS_W-1:0]             position_in;
    } t_in_item;

    typedef struct packed {
        logic                         ok;
        logic signed [CDE_DATA_W-1:0] data_out;
        logic [POS_W-1:0]             position_out;
        logic [CNT_W-1:0]             count_out;
    } t_out_item;

endpackage

FILE: hw/rtl/cde_ram.sv
module cde_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/cde_slot.sv
module cde_slot #(
    parameter int DEPTH = 64
) (
    input  logic [$clog2(DEPTH)-1:0] i_head,
    input  logic [$clog2(DEPTH)-1:0] i_offset,
    output logic [$clog2(DEPTH)-1:0] o_slot
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW:0] DEPTH_S = (AW+1)'(DEPTH);

    logic [AW:0] sum;
    logic [AW:0] wrapped;

    // head + offset modulo the ring size; both terms are below DEPTH
    always_comb begin
        sum     = {1'b0, i_head} + {1'b0, i_offset};
        wrapped = (sum >= DEPTH_S) ? (sum - DEPTH_S) : sum;
        o_slot  = wrapped[AW-1:0];
    end

endmodule

FILE: hw/rtl/circular_deque_engine.sv
// Double-ended queue over a ring of DEPTH entries, one operation per input item and one
// result item per input item. Items run one at a time through a small sequencer that shares
// a single ring-address adder and a single-port-read RAM: a push passes S_EXEC and S_DONE, pop
// back and read pass S_EXEC, S_FETCH and S_DONE, pop front and rotate pass S_EXEC, S_FETCH,
// S_STEP and S_DONE, and a find reads and compares one stored entry per cycle in S_SCAN through
// the RAM read port. Results sit in an output register, so a stalled result does not hold up
// the work on the next item; the input is stalled only while an item is in progress.
module circular_deque_engine #(
    parameter int DEPTH = cde_pkg::CDE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  cde_pkg::t_in_item  i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output cde_pkg::t_out_item o_out_item
);

    import cde_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = CW + POS_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_FETCH = 6'b000100,
        S_STEP  = 6'b001000,
        S_SCAN  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state    r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_cmp_idx, n_cmp_idx;
    logic      r_pend, n_pend;
    t_in_item  r_item, n_item;
    t_out_item r_res, n_res;
    t_out_item r_out, n_out;
    logic      r_out_valid, n_out_valid;

    logic [AW-1:0]         slot_off;
    logic [AW-1:0]         slot;
    logic                  ram_we;
    logic [CDE_DATA_W-1:0] ram_wdata;
    logic [CDE_DATA_W-1:0] ram_rdata;

    cde_slot #(.DEPTH(DEPTH)) u_slot (
        .i_head   (r_head),
        .i_offset (slot_off),
        .o_slot   (slot)
    );

    cde_ram #(.WIDTH(CDE_DATA_W), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (slot),
        .i_wdata (ram_wdata),
        .i_raddr (slot),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_idx       = r_idx;
        n_cmp_idx   = r_cmp_idx;
        n_pend      = r_pend;
        n_item      = r_item;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        slot_off    = '0;
        ram_we      = 1'b0;
        ram_wdata   = r_item.data_in;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_item;
                    n_res   = '0;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                case (r_item.func)
                    FN_PUSH_FRONT: begin
                        if (r_count < DEPTH_C) begin
                            slot_off  = AW'(DEPTH - 1);
                            ram_we    = 1'b1;
                            n_head    = slot;
                            n_count   = r_count + 1'b1;
                            n_res.ok  = 1'b1;
                        end
                    end
                    FN_PUSH_BACK: begin
                        if (r_count < DEPTH_C) begin
                            slot_off  = AW'(r_count);
                            ram_we    = 1'b1;
                            n_count   = r_count + 1'b1;
                            n_res.ok  = 1'b1;
                        end
                    end
                    FN_POP_FRONT, FN_ROTATE: begin
                        if (r_count != '0) begin
                            n_state = S_FETCH;
                        end
                    end
                    FN_POP_BACK: begin
                        if (r_count != '0) begin
                            slot_off = AW'(r_count - 1'b1);
                            n_state  = S_FETCH;
                        end
                    end
                    FN_READ: begin
                        if (CMPW'(r_item.position_in) < CMPW'(r_count)) begin
                            slot_off = AW'(r_item.position_in);
                            n_state  = S_FETCH;
                        end
                    end
                    FN_FIND: begin
                        n_idx   = '0;
                        n_pend  = 1'b0;
                        n_state = S_SCAN;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_FETCH: begin
                case (r_item.func)
                    FN_ROTATE: begin
                        // copy the first entry to the slot past the last one
                        slot_off  = (r_count == DEPTH_C) ? '0 : AW'(r_count);
                        ram_we    = 1'b1;
                        ram_wdata = ram_rdata;
                        n_state   = S_STEP;
                    end
                    FN_POP_FRONT: begin
                        n_res.ok       = 1'b1;
                        n_res.data_out = ram_rdata;
                        n_count        = r_count - 1'b1;
                        n_state        = S_STEP;
                    end
                    FN_POP_BACK: begin
                        n_res.ok       = 1'b1;
                        n_res.data_out = ram_rdata;
                        n_count        = r_count - 1'b1;
                        n_state        = S_DONE;
                    end
                    default: begin
                        n_res.ok       = 1'b1;
                        n_res.data_out = ram_rdata;
                        n_state        = S_DONE;
                    end
                endcase
            end
            S_STEP: begin
                // advance the head past the old first element
                slot_off = AW'(1);
                n_head   = slot;
                n_res.ok = 1'b1;
                n_state  = S_DONE;
            end
            S_SCAN: begin
                slot_off = AW'(r_idx);
                if (r_pend && (ram_rdata == r_item.data_in)) begin
                    n_res.ok           = 1'b1;
                    n_res.position_out = POS_W'(r_cmp_idx);
                    n_state            = S_DONE;
                end else if (r_idx < r_count) begin
                    n_cmp_idx = AW'(r_idx);
                    n_idx     = r_idx + 1'b1;
                    n_pend    = 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out           = r_res;
                    n_out.count_out = CNT_W'(r_count);
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_cmp_idx <= n_cmp_idx;
        r_pend    <= n_pend;
        r_item    <= n_item;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

FILE: hw/rtl/cde_checker.sv
module cde_checker #(
    parameter int DEPTH = cde_pkg::CDE_DEPTH
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input cde_pkg::t_out_item o_out_item
);

    import cde_pkg::*;

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result item changed");

    // an accepted item closes the input until its work is done
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while an item is in progress");

    // a failed operation reports no value and no position
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.ok |->
            (o_out_item.data_out == '0) && (o_out_item.position_out == '0))
        else $error("failed item carries data");

    // the element count never exceeds the ring size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (int'(o_out_item.count_out) <= DEPTH))
        else $error("count beyond ring size");

endmodule

bind circular_deque_engine cde_checker #(.DEPTH(DEPTH)) u_cde_checker (.*);
